// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared defaults, command and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int PRIO_WIDTH_DEFAULT  = 8;

   localparam int STATUS_WIDTH = 2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // Per-cycle operation broadcast to every cell of the row.
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

endpackage

// ----- hdl/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted row: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH  = spq_pkg::PRIO_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  spq_pkg::cell_ctrl_type    ctrl,
   input  logic                      occupied,
   input  logic [VALUE_WIDTH-1:0]    new_value,
   input  logic [PRIO_WIDTH-1:0]     new_prio,
   input  logic                      left_keep,
   input  logic [VALUE_WIDTH-1:0]    left_value,
   input  logic [PRIO_WIDTH-1:0]     left_prio,
   input  logic [VALUE_WIDTH-1:0]    right_value,
   input  logic [PRIO_WIDTH-1:0]     right_prio,
   output logic [VALUE_WIDTH-1:0]    cell_value,
   output logic [PRIO_WIDTH-1:0]     cell_prio,
   output logic                      keep
);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [PRIO_WIDTH-1:0]  prio_ff, prio_in;

   // A held entry of equal or higher priority stays ahead of the new one.
   assign keep = occupied && (prio_ff >= new_prio);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctrl.deq) begin
         value_in = right_value;
         prio_in  = right_prio;
      end else if (ctrl.enq && !keep) begin
         if (left_keep) begin
            value_in = new_value;
            prio_in  = new_prio;
         end else begin
            value_in = left_value;
            prio_in  = left_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign cell_value = value_ff;
   assign cell_prio  = prio_ff;

endmodule

// ----- hdl/stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded queue of DEPTH entries, kept sorted by descending priority.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as items on the req_ channel. req_tuser selects the
// operation (enqueue or dequeue); req_tdata carries the value and priority
// of an entry to insert. Every accepted item produces exactly one result
// item on the rsp_ channel, carrying a status in rsp_tuser and the removed
// value, its priority and the resulting occupancy in rsp_tdata.
// Entries of equal priority leave in the order they arrived. An enqueue on
// a full queue is dropped and reported as full; a dequeue on an empty queue
// is reported as empty, with zero value and priority.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle while the receiver takes each result, set by the row of
// cells that inserts or shifts out one entry for each accepted item.
// A new item is accepted whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds the result and
// back-pressures the request side after one item.
// Reset empties the queue and drops any pending result; entry contents are
// not cleared, as slots beyond the occupancy are never read.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
   parameter int DEPTH       = spq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEFAULT,
   parameter int PRIO_WIDTH  = spq_pkg::PRIO_WIDTH_DEFAULT,
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1),
   localparam int REQ_TDATA_WIDTH = ((VALUE_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
   localparam int RSP_TDATA_WIDTH =
      ((VALUE_WIDTH + PRIO_WIDTH + CNT_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: value, priority_req, zero padding.
   input  logic [REQ_TDATA_WIDTH-1:0]          req_tdata,
   // Fields: cmd.
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0 up: out_value, out_priority, occupancy, zero padding.
   output logic [RSP_TDATA_WIDTH-1:0]          rsp_tdata,
   // Fields: status.
   output logic [spq_pkg::STATUS_WIDTH-1:0]    rsp_tuser
);

   logic                   req_fire;
   logic                   full, empty;
   logic [VALUE_WIDTH-1:0] new_value;
   logic [PRIO_WIDTH-1:0]  new_prio;
   spq_pkg::cell_ctrl_type ctrl;

   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::STATUS_WIDTH-1:0]  status_ff, status_in;
   logic [VALUE_WIDTH-1:0]            out_value_ff, out_value_in;
   logic [PRIO_WIDTH-1:0]             out_prio_ff, out_prio_in;
   logic [CNT_WIDTH-1:0]              occ_ff;

   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [PRIO_WIDTH-1:0]  cell_prio  [DEPTH];
   logic [DEPTH-1:0]       cell_keep;

   // The output register frees up when it is empty or drained this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign new_value = req_tdata[VALUE_WIDTH-1:0];
   assign new_prio  = req_tdata[VALUE_WIDTH+PRIO_WIDTH-1:VALUE_WIDTH];

   assign full  = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);

   assign ctrl.enq = req_fire && (req_tuser == spq_pkg::CMD_ENQUEUE) && !full;
   assign ctrl.deq = req_fire && (req_tuser == spq_pkg::CMD_DEQUEUE) && !empty;

   // Row of cells. Slot 0 is the head. On an enqueue each cell looks at its
   // left neighbor to decide whether it takes the new entry or shifts; on a
   // dequeue every cell takes its right neighbor's entry.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                   l_keep;
      logic [VALUE_WIDTH-1:0] l_value, r_value;
      logic [PRIO_WIDTH-1:0]  l_prio, r_prio;

      if (i == 0) begin : g_head
         assign l_keep  = 1'b1;
         assign l_value = new_value;
         assign l_prio  = new_prio;
      end else begin : g_body
         assign l_keep  = cell_keep[i-1];
         assign l_value = cell_value[i-1];
         assign l_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_value = cell_value[i];
         assign r_prio  = cell_prio[i];
      end else begin : g_inner
         assign r_value = cell_value[i+1];
         assign r_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .PRIO_WIDTH  (PRIO_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CNT_WIDTH'(i) < count_ff),
         .new_value   (new_value),
         .new_prio    (new_prio),
         .left_keep   (l_keep),
         .left_value  (l_value),
         .left_prio   (l_prio),
         .right_value (r_value),
         .right_prio  (r_prio),
         .cell_value  (cell_value[i]),
         .cell_prio   (cell_prio[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.enq) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   // Result fields for the item being accepted.
   always_comb begin
      status_in    = spq_pkg::STATUS_OK;
      out_value_in = '0;
      out_prio_in  = '0;
      if (req_tuser == spq_pkg::CMD_ENQUEUE) begin
         if (full) begin
            status_in = spq_pkg::STATUS_FULL;
         end
      end else begin
         if (empty) begin
            status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            out_value_in = cell_value[0];
            out_prio_in  = cell_prio[0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff    <= status_in;
         out_value_ff <= out_value_in;
         out_prio_ff  <= out_prio_in;
         occ_ff       <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'({occ_ff, out_prio_ff, out_value_ff});

   // The fill count never runs past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("queue occupancy exceeds depth");

   // A successful insert grows the queue by exactly one entry.
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.enq |=> count_ff == $past(count_ff) + CNT_WIDTH'(1))
      else $error("enqueue did not add one entry");

   // A dequeue on an empty queue reports empty in the next result.
   a_deq_empty: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == spq_pkg::CMD_DEQUEUE) && empty)
      |=> rsp_tvalid && (rsp_tuser == spq_pkg::STATUS_EMPTY))
      else $error("dequeue on empty queue not reported");

   // The row stays sorted: the new head never outranks the entry just removed.
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (ctrl.deq && (count_ff > CNT_WIDTH'(1))) |=> out_prio_ff >= cell_prio[0])
      else $error("queue head out of priority order");

endmodule
